/* rtl/core/fvn_pkg.sv */
`timescale 1ns / 1ps
package fvn_pkg;

    localparam int PADDR_W = 3;
    localparam int NUM_OCT = 4;
    localparam int NUM_CORNER = 8;

    localparam logic [31:0] HASH_MUL_Y = 32'd57;
    localparam logic [31:0] HASH_MUL_Z = 32'd3251;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] HASH_MUL_SQ = 32'd15731;
    localparam logic [31:0] HASH_ADD_SQ = 32'd789221;
    localparam logic [31:0] HASH_ADD_OUT = 32'd1376312589;

    localparam logic [15:0] PERS_ONE = 16'd32768;
    localparam logic [15:0] PERS_RESET = 16'd16384;

    // Per-axis setup for one octave of one point.
    typedef struct packed {
        logic             valid;
        logic [1:0]       k;
        logic [2:0][31:0] lo;
        logic [2:0][31:0] hi;
        logic [2:0][15:0] wc;
    } t_oct_req;

    // log2 of the cell size for each octave: 1024, 256, 64, 16
    function automatic logic [4:0] oct_log2(input logic [1:0] k);
        logic [4:0] r;
        case (k)
            2'd0: r = 5'd10;
            2'd1: r = 5'd8;
            2'd2: r = 5'd6;
            default: r = 5'd4;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/fvn_octave.sv */
`timescale 1ns / 1ps
module fvn_octave
    import fvn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_oct_req    i_req,
    output logic        o_valid,
    output logic [1:0]  o_k,
    output logic [31:0] o_value
);

    logic [5:0]      r_v;
    logic [5:0][1:0] r_k;

    logic [NUM_CORNER-1:0][31:0] r_n1_a, r_n1_b, r_n1_c, n_n1;
    logic [NUM_CORNER-1:0][16:0] r_wxy, r_wz, r_w_b, r_w_c, r_w_d, n_wxy, n_wz, n_w;
    logic [NUM_CORNER-1:0][31:0] r_sq, r_t, n_sq, n_t;
    logic [NUM_CORNER-1:0][30:0] r_h, n_h;
    logic [NUM_CORNER-1:0][47:0] r_prod, n_prod;
    logic [31:0]                 r_value, n_value;

    // stage 1: corner hash premix and xy weight
    always_comb begin
        logic [31:0] x, y, z, n0;
        logic [16:0] wx, wy;
        for (int j = 0; j < NUM_CORNER; j++) begin
            x  = j[2] ? i_req.hi[0] : i_req.lo[0];
            y  = j[1] ? i_req.hi[1] : i_req.lo[1];
            z  = j[0] ? i_req.hi[2] : i_req.lo[2];
            n0 = x + 32'(y * HASH_MUL_Y) + 32'(z * HASH_MUL_Z);
            n_n1[j] = (n0 << HASH_SHIFT) ^ n0;
            wx = j[2] ? {1'b0, i_req.wc[0]} : 17'(18'h10000 - {2'b0, i_req.wc[0]});
            wy = j[1] ? {1'b0, i_req.wc[1]} : 17'(18'h10000 - {2'b0, i_req.wc[1]});
            n_wz[j] = j[0] ? {1'b0, i_req.wc[2]} : 17'(18'h10000 - {2'b0, i_req.wc[2]});
            n_wxy[j] = 17'((34'(wx) * 34'(wy)) >> 16);
        end
    end

    // stages 2 to 5: hash multiplies, full weight, weighted corner
    always_comb begin
        for (int j = 0; j < NUM_CORNER; j++) begin
            n_sq[j]   = 32'(r_n1_a[j] * r_n1_a[j]);
            n_w[j]    = 17'((34'(r_wxy[j]) * 34'(r_wz[j])) >> 16);
            n_t[j]    = 32'(r_sq[j] * HASH_MUL_SQ) + HASH_ADD_SQ;
            n_h[j]    = 31'(32'(r_n1_c[j] * r_t[j]) + HASH_ADD_OUT);
            n_prod[j] = 48'(r_h[j]) * 48'(r_w_d[j]);
        end
    end

    // stage 6: sum corners
    always_comb begin
        logic [50:0] sum;
        sum = '0;
        for (int j = 0; j < NUM_CORNER; j++) begin
            sum = sum + 51'(r_prod[j]);
        end
        n_value = 32'(sum >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_req.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k    <= {r_k[4:0], i_req.k};
            r_n1_a <= n_n1;
            r_wxy  <= n_wxy;
            r_wz   <= n_wz;
            r_sq   <= n_sq;
            r_n1_b <= r_n1_a;
            r_w_b  <= n_w;
            r_t    <= n_t;
            r_n1_c <= r_n1_b;
            r_w_c  <= r_w_b;
            r_h    <= n_h;
            r_w_d  <= r_w_c;
            r_prod <= n_prod;
            r_value <= n_value;
        end
    end

    assign o_valid = r_v[5];
    assign o_k     = r_k[5];
    assign o_value = r_value;

endmodule

/* rtl/core/fractal_value_noise_3d.sv */
`timescale 1ns / 1ps
// The shared octave pipeline takes one octave of one point per cycle unless the
// result waits to be taken, and a point has four octaves; a new point is accepted
// as the last octave of the previous point issues.
// Reset (i_rst_n low at a clock edge) clears all valid bits and the issue
// counter and sets persistence to 16384 (0.5).
module fractal_value_noise_3d
    import fvn_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_coord_x,
    input  logic signed [31:0]  i_coord_y,
    input  logic signed [31:0]  i_coord_z,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [17:0]  o_noise_value,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int F = COORD_FRAC_BITS;

    // configuration and derived persistence powers
    logic [15:0] r_pers, r_p1, r_p2, r_p3;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'b0, r_pers} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pers <= PERS_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
            r_pers <= pwdata[15:0];
        end
    end

    // clamp above 1.0, then build p^2 and p^3 over two register steps
    always_ff @(posedge i_clk) begin
        r_p1 <= (r_pers > PERS_ONE) ? PERS_ONE : r_pers;
        r_p2 <= 16'((32'(r_p1) * 32'(r_p1)) >> 15);
        r_p3 <= 16'((32'(r_p2) * 32'(r_p1)) >> 15);
    end

    // global advance: hold everything while the result waits to be taken
    logic en;
    assign en = !(o_out_valid && !i_out_ready);

    // issue: hold the point and feed four octaves into the pipeline
    logic        r_busy;
    logic [1:0]  r_oct;
    logic [31:0] r_cx, r_cy, r_cz;
    logic        in_acc;

    assign o_in_ready = en && (!r_busy || (r_oct == 2'd3));
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_oct  <= 2'd0;
        end else if (en) begin
            if (in_acc) begin
                r_busy <= 1'b1;
                r_oct  <= 2'd0;
            end else if (r_busy) begin
                r_busy <= (r_oct != 2'd3);
                r_oct  <= r_oct + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_cx <= i_coord_x;
            r_cy <= i_coord_y;
            r_cz <= i_coord_z;
        end
    end

    // lattice corners and 16-bit cell weight of one axis
    function automatic logic [79:0] axis_setup(input logic [31:0] c, input logic [4:0] lg);
        logic [31:0] ip, lo, hi, cell_sz;
        logic [47:0] off;
        logic [15:0] wc;
        ip      = 32'($signed(c) >>> F);
        cell_sz = 32'(1) << lg;
        lo      = ip & ~(cell_sz - 32'd1);
        hi      = lo + cell_sz;
        off     = {16'b0, c} & ((48'(1) << (F + 32'(lg))) - 48'd1);
        wc      = 16'((off << 16) >> (F + 32'(lg)));
        return {lo, hi, wc};
    endfunction

    t_oct_req r_req, n_req;

    always_comb begin
        logic [4:0]  lg;
        logic [79:0] ax, ay, az;
        lg = oct_log2(r_oct);
        ax = axis_setup(r_cx, lg);
        ay = axis_setup(r_cy, lg);
        az = axis_setup(r_cz, lg);
        n_req.valid = r_busy;
        n_req.k     = r_oct;
        n_req.lo    = {az[79:48], ay[79:48], ax[79:48]};
        n_req.hi    = {az[47:16], ay[47:16], ax[47:16]};
        n_req.wc    = {az[15:0], ay[15:0], ax[15:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req.valid <= 1'b0;
        end else if (en) begin
            r_req.valid <= n_req.valid;
        end
        if (en) begin
            r_req.k  <= n_req.k;
            r_req.lo <= n_req.lo;
            r_req.hi <= n_req.hi;
            r_req.wc <= n_req.wc;
        end
    end

    logic        oct_v;
    logic [1:0]  oct_k;
    logic [31:0] oct_value;

    fvn_octave u_octave (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_req   (r_req),
        .o_valid (oct_v),
        .o_k     (oct_k),
        .o_value (oct_value)
    );

    // octave term: first octave unscaled, later ones centered on one half
    // and scaled by p^k
    logic               r_term_v;
    logic [1:0]         r_term_k;
    logic signed [35:0] r_term, n_term;

    always_comb begin
        logic signed [32:0] dev;
        logic signed [49:0] sc;
        logic [15:0]        pk;
        case (oct_k)
            2'd1: pk = r_p1;
            2'd2: pk = r_p2;
            default: pk = r_p3;
        endcase
        dev = $signed({1'b0, oct_value}) - 33'sd1073741824;
        sc  = 50'(dev) * $signed({34'b0, pk});
        if (oct_k == 2'd0) begin
            n_term = $signed({4'b0, oct_value});
        end else begin
            n_term = 36'(sc >>> 15) + 36'sd1073741824;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_term_v <= 1'b0;
        end else if (en) begin
            r_term_v <= oct_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_term_k <= oct_k;
            r_term   <= n_term;
        end
    end

    // accumulate four terms, then halve, recenter and saturate
    logic signed [35:0] r_acc, n_tot;
    logic signed [17:0] r_out, n_out;
    logic               r_out_valid;

    always_comb begin
        logic signed [35:0] r;
        n_tot = (r_term_k == 2'd0) ? r_term : (r_acc + r_term);
        r = (n_tot - 36'sd2147483648) >>> 16;
        if (r > 36'sd131071) begin
            n_out = 18'sd131071;
        end else if (r < -36'sd131072) begin
            n_out = -18'sd131072;
        end else begin
            n_out = 18'(r);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_term_v) begin
            r_acc <= n_tot;
        end
        if (en && r_term_v && (r_term_k == 2'd3)) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_term_v && (r_term_k == 2'd3);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_noise_value = r_out;

    a_last_term_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_term_v && (r_term_k == 2'd3)) |=> r_out_valid)
        else $error("last octave term did not produce a result");

    a_issue_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && !en) |=> ($stable(r_oct) && r_busy))
        else $error("issue counter moved during a stall");

    a_accept_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (!r_busy || (r_oct == 2'd3)))
        else $error("request accepted while octaves still issuing");

endmodule

/* sim/fractal_value_noise_3d_tb.sv */
`timescale 1ns / 1ps
module fractal_value_noise_3d_tb;
    import fvn_pkg::*;

    localparam int                 FRAC_BITS = 8;
    localparam logic [PADDR_W-1:0] ADDR_PERSISTENCE = '0;
    localparam int                 CYCLE_LIMIT = 600000;
    localparam int                 DRAIN_CYCLES = 16;
    localparam int                 NUM_PHASES = 9;
    localparam int                 PHASE_POINTS = 150;

    // Bit-accurate model of the fractal noise sum plus the queue of pending values.
    class noise_board;
        logic [17:0] pending_noise[$];
        int          errors;
        int          checked;

        function new();
            errors = 0;
            checked = 0;
        endfunction

        function logic [30:0] lattice_hash(logic [31:0] x, logic [31:0] y, logic [31:0] z);
            logic [31:0] n;
            n = x + y * HASH_MUL_Y + z * HASH_MUL_Z;
            n = (n << HASH_SHIFT) ^ n;
            n = n * (n * n * HASH_MUL_SQ + HASH_ADD_SQ) + HASH_ADD_OUT;
            return n[30:0];
        endfunction

        // One octave in Q0.31 for cell size 2^lg.
        function longint unsigned octave_value(logic [2:0][31:0] c, int lg);
            logic [31:0]     lo[3];
            logic [31:0]     hi[3];
            longint unsigned wc[3];
            longint unsigned wd[3];
            longint unsigned off;
            longint unsigned wx, wy, wz, w;
            longint unsigned acc;
            logic [31:0]     ip;
            acc = 0;
            for (int a = 0; a < 3; a++) begin
                ip = $signed(c[a]) >>> FRAC_BITS;
                off = longint'(c[a]) & ((64'd1 << (FRAC_BITS + lg)) - 1);
                lo[a] = ip & ~((32'd1 << lg) - 32'd1);
                hi[a] = lo[a] + (32'd1 << lg);
                wc[a] = (off << 16) >> (FRAC_BITS + lg);
                wd[a] = 65536 - wc[a];
            end
            for (int i = 0; i < NUM_CORNER; i++) begin
                wx = i[2] ? wc[0] : wd[0];
                wy = i[1] ? wc[1] : wd[1];
                wz = i[0] ? wc[2] : wd[2];
                w = (((wx * wy) >> 16) * wz) >> 16;
                acc += longint'(lattice_hash(i[2] ? hi[0] : lo[0], i[1] ? hi[1] : lo[1],
                                             i[0] ? hi[2] : lo[2])) * w;
            end
            return acc >> 16;
        endfunction

        function void note_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [15:0] pers);
            logic [2:0][31:0] c;
            longint           p, pk, total, dev, r;
            c = {z, y, x};
            p = (pers > PERS_ONE) ? longint'(PERS_ONE) : longint'(pers);
            pk = 32768;
            total = longint'(octave_value(c, oct_log2(2'd0)));
            for (int k = 1; k < NUM_OCT; k++) begin
                // Raise persistence one power per octave, truncating in Q1.15.
                pk = (k == 1) ? p : ((pk * p) >>> 15);
                dev = longint'(octave_value(c, oct_log2(k[1:0]))) - (64'sd1 <<< 30);
                total += (64'sd1 <<< 30) + ((dev * pk) >>> 15);
            end
            r = (total - (64'sd1 <<< 31)) >>> 16;
            if (r > 131071) r = 131071;
            if (r < -131072) r = -131072;
            pending_noise.push_back(r[17:0]);
        endfunction

        function void check_noise(logic [17:0] got);
            logic [17:0] want;
            checked++;
            if (pending_noise.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %0d",
                         $time, $signed(got));
                return;
            end
            want = pending_noise.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: noise_value mismatch: expected %0d, actual %0d",
                         $time, $signed(want), $signed(got));
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic signed [31:0] i_coord_x;
    logic signed [31:0] i_coord_y;
    logic signed [31:0] i_coord_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [17:0] o_noise_value;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    noise_board  sb;
    logic [15:0] pers_now;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cycle_count;
    logic [15:0] pers_plan[NUM_PHASES];
    int          mode_plan[NUM_PHASES];

    fractal_value_noise_3d #(.COORD_FRAC_BITS(FRAC_BITS)) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_coord_x    (i_coord_x),
        .i_coord_y    (i_coord_y),
        .i_coord_z    (i_coord_z),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_noise_value(o_noise_value),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // Bound the run; a hang means a lost request or result.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Check each accepted result, then randomize backpressure for the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_noise(o_noise_value);
        end
        if (recv_idle_pct == 0) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Mix full-range words, points near the origin and points near the wrap limits.
    function automatic logic [31:0] pick_coord();
        int sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0: return 32'($urandom_range(0, 16383)) - 32'd8192;
            1: return {1'b0, 15'h7fff, 16'($urandom)} ^ {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'h0};
            default: return $urandom;
        endcase
    endfunction

    // Drive one request; hold valid and payload until accepted.
    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_coord_x <= x;
        i_coord_y <= y;
        i_coord_z <= z;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_point(x, y, z, pers_now);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending_noise.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle; the register takes the data on the access edge.
    task automatic write_persistence(logic [15:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_PERSISTENCE;
        pwdata <= {16'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        pers_now = value;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            0: begin
                send_idle_pct = 17;
                recv_idle_pct = 49;
            end
            1: begin
                send_idle_pct = 49;
                recv_idle_pct = 17;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        pers_now = PERS_RESET;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_out_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points at reset persistence: origin, extremes, wrap and cell edges.
        set_idling(2);
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
        send_point(32'h80000000, 32'h80000000, 32'h80000000);
        send_point(32'hffffffff, 32'hffffffff, 32'hffffffff);
        send_point(32'h7fffffff, 32'h80000000, 32'h0);
        send_point(32'h80000000, 32'hffffffff, 32'h7fffffff);
        send_point(32'h1, 32'h0, 32'h0);
        send_point(32'h0, 32'h1, 32'h0);
        send_point(32'h0, 32'h0, 32'h1);
        send_point(32'h0003ffff, 32'h00040000, 32'hfffc0000);
        send_point(32'h0000ffff, 32'h00010000, 32'hffff0000);
        send_point(32'h00000fff, 32'h00001000, 32'hfffff000);
        send_point(32'h7fffff00, 32'h800000ff, 32'h000000ff);
        send_point(32'h55555555, 32'haaaaaaaa, 32'h12345678);
        send_point(32'haaaaaaaa, 32'h55555555, 32'hedcba987);
        send_point(32'h00000080, 32'hffffff80, 32'h00020000);
        drain();

        // Sweep persistence through zero, one, above range and odd values.
        pers_plan = '{16'd0, 16'd32768, 16'd65535, 16'd1, 16'd16384,
                      16'd32769, 16'd0, 16'd32767, 16'd0};
        mode_plan = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
        pers_plan[8] = 16'($urandom);
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_persistence(pers_plan[ph]);
            set_idling(mode_plan[ph]);
            for (int n = 0; n < PHASE_POINTS; n++) begin
                send_point(pick_coord(), pick_coord(), pick_coord());
            end
            drain();
        end

        $display("Checked %0d noise results over %0d persistence settings,", sb.checked,
                 NUM_PHASES + 1);
        $display("with sender and receiver stalls, extreme and wrapping coordinates.");
        if (sb.errors == 0 && sb.pending_noise.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/fvn_pkg.sv
rtl/core/fvn_octave.sv
rtl/core/fractal_value_noise_3d.sv
sim/fractal_value_noise_3d_tb.sv
